@@ hw/rtl/single_qubit_gate_apply_macros.svh @@
// assertion helpers used by the checker
`ifndef SINGLE_QUBIT_GATE_APPLY_MACROS_SVH
`define SINGLE_QUBIT_GATE_APPLY_MACROS_SVH

// same-cycle implication
`define SQGA_ASSERT_SAME(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("sqga assertion failed");

// next-cycle implication
`define SQGA_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("sqga assertion failed");

`endif

@@ hw/rtl/sqga_pkg.sv @@
package sqga_pkg;

  localparam int SQGA_NUM_QUBITS = 10;

  localparam int AMP_W     = 18;
  localparam int FRAC_W    = 16;
  localparam int INDEX_W   = 10;
  localparam int TARGET_W  = 4;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_COEF  = 8;
  localparam int PROD_W    = 2 * AMP_W;
  localparam int ACC_W     = PROD_W + 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE = 2'd0,
    MODE_GATE  = 2'd1,
    MODE_READ  = 2'd2
  } mode_t;

  typedef logic signed [AMP_W-1:0] q16_t;

  typedef struct packed {
    q16_t re;
    q16_t im;
  } amp_t;

  localparam q16_t Q_MAX = 18'sh1ffff;
  localparam q16_t Q_MIN = 18'sh20000;

  // identity matrix after reset
  localparam q16_t COEF_RESET [NUM_COEF] = '{
    18'sh10000, 18'sh00000, 18'sh00000, 18'sh00000,
    18'sh00000, 18'sh00000, 18'sh10000, 18'sh00000
  };

  // half an lsb of the q1.16 result, preloaded into the accumulator
  localparam logic signed [ACC_W-1:0] ROUND_HALF = 38'sd32768;

  // q5.32 sum (already offset by half an lsb) to saturated q1.16
  function automatic q16_t sat_q16(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-FRAC_W-1:0] q;
    q = acc[ACC_W-1:FRAC_W];
    if (q > Q_MAX) begin
      return Q_MAX;
    end else if (q < Q_MIN) begin
      return Q_MIN;
    end else begin
      return q[AMP_W-1:0];
    end
  endfunction

endpackage

@@ hw/rtl/sqga_if.sv @@
interface sqga_req_if import sqga_pkg::*;;
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [INDEX_W-1:0]  index;
  q16_t                amp_in_re;
  q16_t                amp_in_im;
  logic [TARGET_W-1:0] target;

  modport source (output valid, mode, index, amp_in_re, amp_in_im, target, input ready);
  modport sink   (input valid, mode, index, amp_in_re, amp_in_im, target, output ready);
endinterface

interface sqga_rsp_if import sqga_pkg::*;;
  logic valid;
  logic ready;
  q16_t amp_out_re;
  q16_t amp_out_im;
  logic status;

  modport source (output valid, amp_out_re, amp_out_im, status, input ready);
  modport sink   (input valid, amp_out_re, amp_out_im, status, output ready);
endinterface

@@ hw/rtl/single_qubit_gate_apply.sv @@
// channel   dir  handshake     payload
// in_req    in   valid/ready   mode, index, amp_in_re, amp_in_im, target
// out_rsp   out  valid/ready   amp_out_re, amp_out_im, status
// cfg       in   cfg_we        cfg_index, cfg_wdata (coefficient registers 0..7)
//
// write, read, no-op and out-of-range gate requests go from idle to the response state, which
// loads the response register once out_rsp can take it. an in-range gate request first takes
// each amplitude pair through two store reads, 16 products on the single 18x18 multiplier
// plus drain, and two writes. after reset a sweep zeroes the store before in_req.ready rises.
// one response is held; the next request is taken while it waits for out_rsp.ready.
module single_qubit_gate_apply
  import sqga_pkg::*;
#(
  parameter int NUM_QUBITS = SQGA_NUM_QUBITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [AMP_W-1:0]     cfg_wdata,
  sqga_req_if.sink             in_req,
  sqga_rsp_if.source           out_rsp
);

  localparam int AW    = NUM_QUBITS;
  localparam int DIM   = 2 ** AW;
  localparam int PW    = (AW > 1) ? AW - 1 : 1;
  localparam int NPAIR = 2 ** (AW - 1);
  localparam int BPW   = (AW > 1) ? $clog2(AW) : 1;
  localparam int TW    = TARGET_W + 1;
  localparam int K_W   = 5;
  localparam int MAC_TERMS = 16;
  localparam int MAC_DRAIN = 2;

  localparam logic [PW-1:0]  LAST_PAIR = PW'(NPAIR - 1);
  localparam logic [AW-1:0]  LAST_ADDR = '1;
  localparam logic [K_W-1:0] MAC_LAST  = K_W'(MAC_TERMS + MAC_DRAIN - 1);

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_RD_A  = 9'b000000100,
    S_RD_B  = 9'b000001000,
    S_LOAD  = 9'b000010000,
    S_MAC   = 9'b000100000,
    S_WR_A  = 9'b001000000,
    S_WR_B  = 9'b010000000,
    S_RESP  = 9'b100000000
  } st_t;

  st_t            st_r, st_nxt;
  logic [AW-1:0]  clr_r, clr_nxt;
  logic [PW-1:0]  pair_r, pair_nxt;
  logic [K_W-1:0] k_r, k_nxt;

  logic [AW-1:0]  idx_r;
  logic [AW-1:0]  bit_r;
  logic [AW-1:0]  low_r;
  logic           status_r;
  logic           rd_sel_r;

  q16_t           coef_r [NUM_COEF];
  amp_t           a0_r, a1_r;
  q16_t           res_r [4];

  amp_t           mem [DIM];
  amp_t           rdata_r;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  amp_t           mem_wdata;
  logic [AW-1:0]  mem_raddr;

  logic signed [PROD_W-1:0] prod_r;
  logic           p_vld_r, p_neg_r, p_first_r, p_last_r;
  logic [1:0]     p_sel_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic           a_last_r;
  logic [1:0]     a_sel_r;

  logic           out_vld_r;
  q16_t           out_re_r, out_im_r;
  logic           out_st_r;

  logic           in_ready;
  logic           accept;
  logic           load_out;

  // request decode
  logic [AW+INDEX_W-1:0] idx_wide;
  logic [AW-1:0]  idx_in;
  logic           tgt_ok;
  logic [TW-1:0]  bpos_w;
  logic [BPW-1:0] bpos;
  logic [AW-1:0]  bit_in, low_in;

  assign idx_wide = {{AW{1'b0}}, in_req.index};
  assign idx_in   = idx_wide[AW-1:0];
  assign tgt_ok   = {1'b0, in_req.target} < TW'(NUM_QUBITS);
  // target 0 is the top address bit
  assign bpos_w   = TW'(NUM_QUBITS - 1) - {1'b0, in_req.target};
  assign bpos     = bpos_w[BPW-1:0];
  assign bit_in   = AW'(1) << bpos;
  assign low_in   = bit_in - AW'(1);
  assign accept   = in_ready && in_req.valid;

  // pair counter with a zero spliced in at the target bit
  logic [AW-1:0]  pair_ext, addr_i, addr_j;

  assign pair_ext = AW'(pair_r);
  assign addr_i   = ((pair_ext & ~low_r) << 1) | (pair_ext & low_r);
  assign addr_j   = addr_i | bit_r;

  always_comb begin
    st_nxt    = st_r;
    clr_nxt   = clr_r;
    pair_nxt  = pair_r;
    k_nxt     = k_r;
    mem_we    = 1'b0;
    mem_waddr = addr_i;
    mem_wdata = '0;
    mem_raddr = idx_r;
    load_out  = 1'b0;
    in_ready  = 1'b0;
    unique case (st_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == LAST_ADDR) begin
          st_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready  = 1'b1;
        mem_raddr = idx_in;
        if (in_req.valid) begin
          unique case (in_req.mode)
            MODE_WRITE: begin
              mem_we    = 1'b1;
              mem_waddr = idx_in;
              mem_wdata = {in_req.amp_in_re, in_req.amp_in_im};
              st_nxt    = S_RESP;
            end
            MODE_GATE: begin
              pair_nxt = '0;
              st_nxt   = tgt_ok ? S_RD_A : S_RESP;
            end
            default: begin
              st_nxt = S_RESP;
            end
          endcase
        end
      end
      S_RD_A: begin
        mem_raddr = addr_i;
        st_nxt    = S_RD_B;
      end
      S_RD_B: begin
        mem_raddr = addr_j;
        st_nxt    = S_LOAD;
      end
      S_LOAD: begin
        mem_raddr = addr_j;
        k_nxt     = '0;
        st_nxt    = S_MAC;
      end
      S_MAC: begin
        k_nxt = k_r + K_W'(1);
        if (k_r == MAC_LAST) begin
          st_nxt = S_WR_A;
        end
      end
      S_WR_A: begin
        mem_we    = 1'b1;
        mem_waddr = addr_i;
        mem_wdata = {res_r[0], res_r[1]};
        st_nxt    = S_WR_B;
      end
      S_WR_B: begin
        mem_we    = 1'b1;
        mem_waddr = addr_j;
        mem_wdata = {res_r[2], res_r[3]};
        if (pair_r == LAST_PAIR) begin
          st_nxt = S_RESP;
        end else begin
          pair_nxt = pair_r + PW'(1);
          st_nxt   = S_RD_A;
        end
      end
      S_RESP: begin
        if (!out_vld_r || out_rsp.ready) begin
          load_out = 1'b1;
          st_nxt   = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_CLEAR;
      clr_r    <= '0;
      pair_r   <= '0;
      k_r      <= '0;
      status_r <= 1'b0;
      rd_sel_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      clr_r  <= clr_nxt;
      pair_r <= pair_nxt;
      k_r    <= k_nxt;
      if (accept) begin
        status_r <= (in_req.mode == MODE_GATE) && !tgt_ok;
        rd_sel_r <= (in_req.mode == MODE_READ);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      idx_r <= idx_in;
      bit_r <= bit_in;
      low_r <= low_in;
    end
    if (st_r == S_RD_B) begin
      a0_r <= rdata_r;
    end
    if (st_r == S_LOAD) begin
      a1_r <= rdata_r;
    end
  end

  // coefficient registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= COEF_RESET;
    end else if (cfg_we) begin
      coef_r[cfg_index] <= cfg_wdata;
    end
  end

  // amplitude store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  // shared multiplier: k = {out sel[1:0], term[1:0]}, coef index = {k[3], k[1], k[0]}
  logic           issue;
  logic [2:0]     cidx;
  amp_t           src;
  logic           use_im;
  q16_t           mul_a, mul_b;

  assign issue  = (st_r == S_MAC) && !k_r[4];
  assign cidx   = {k_r[3], k_r[1], k_r[0]};
  assign src    = k_r[1] ? a1_r : a0_r;
  assign use_im = k_r[0] ^ k_r[2];
  assign mul_a  = coef_r[cidx];
  assign mul_b  = use_im ? src.im : src.re;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r  <= 1'b0;
      a_last_r <= 1'b0;
    end else begin
      p_vld_r  <= issue;
      a_last_r <= p_vld_r && p_last_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r    <= mul_a * mul_b;
    // imaginary times imaginary enters the real part negated
    p_neg_r   <= k_r[0] & ~k_r[2];
    p_first_r <= (k_r[1:0] == 2'b00);
    p_last_r  <= (k_r[1:0] == 2'b11);
    p_sel_r   <= k_r[3:2];
    a_sel_r   <= p_sel_r;
    if (p_vld_r) begin
      if (p_neg_r) begin
        acc_r <= (p_first_r ? ROUND_HALF : acc_r) - {{2{prod_r[PROD_W-1]}}, prod_r};
      end else begin
        acc_r <= (p_first_r ? ROUND_HALF : acc_r) + {{2{prod_r[PROD_W-1]}}, prod_r};
      end
    end
    if (a_last_r) begin
      res_r[a_sel_r] <= sat_q16(acc_r);
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (load_out) begin
      out_vld_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_re_r <= rd_sel_r ? rdata_r.re : '0;
      out_im_r <= rd_sel_r ? rdata_r.im : '0;
      out_st_r <= status_r;
    end
  end

  assign in_req.ready       = in_ready;
  assign out_rsp.valid      = out_vld_r;
  assign out_rsp.amp_out_re = out_re_r;
  assign out_rsp.amp_out_im = out_im_r;
  assign out_rsp.status     = out_st_r;

endmodule

@@ hw/rtl/sqga_checker.sv @@
`include "single_qubit_gate_apply_macros.svh"

module sqga_checker
  import sqga_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input q16_t out_re,
  input q16_t out_im,
  input logic out_status
);

  logic out_stall;
  logic amp_zero;

  assign out_stall = out_valid && !out_ready;
  assign amp_zero  = (out_re == '0) && (out_im == '0);

  // one request at a time
  `SQGA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  // an error response carries no amplitude
  `SQGA_ASSERT_SAME(a_status_zero_amp, clk, rst_n, out_valid && out_status, amp_zero)
  `SQGA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid)
  `SQGA_ASSERT_NEXT(a_out_stable, clk, rst_n, out_stall, $stable({out_re, out_im, out_status}))

endmodule

bind single_qubit_gate_apply sqga_checker u_sqga_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_req.valid),
  .in_ready   (in_req.ready),
  .out_valid  (out_rsp.valid),
  .out_ready  (out_rsp.ready),
  .out_re     (out_rsp.amp_out_re),
  .out_im     (out_rsp.amp_out_im),
  .out_status (out_rsp.status)
);
